/* design/htfd_pkg.sv */
// Shared types and event codes for the humidity/temperature frame decoder.
package htfd_pkg;

  // Event codes; each code is also the bit position in the pending event mask.
  localparam logic [2:0] KindRecovered = 3'd0;
  localparam logic [2:0] KindTemp      = 3'd1;
  localparam logic [2:0] KindHum       = 3'd2;
  localparam logic [2:0] KindChanged   = 3'd3;
  localparam logic [2:0] KindFailed    = 3'd4;

  localparam int unsigned EvCount = 5;

  // Decoded frame, as handed from the decoder to the event emitter.
  typedef struct packed {
    logic [EvCount-1:0] ev_mask;
    logic signed [15:0] temp;
    logic [14:0]        hum;
    logic               good;
  } htfd_dec_t;

endpackage

/* design/htfd_decode.sv */
// Frame check, fixed-point decode and change detection for one frame.
module htfd_decode import htfd_pkg::*; (
  input  logic               bus_ok_i,
  input  logic [7:0]         hum_int_i,
  input  logic [7:0]         hum_frac_i,
  input  logic [7:0]         temp_int_i,
  input  logic [7:0]         temp_frac_sign_i,
  input  logic [7:0]         check_byte_i,
  input  logic signed [15:0] stored_temp_i,
  input  logic [14:0]        stored_hum_i,
  input  logic               reading_valid_i,
  input  logic               failure_latched_i,
  output htfd_dec_t          dec_o
);

  logic [7:0]  sum;
  logic [14:0] hum;
  logic [14:0] mag;
  logic signed [15:0] temp;
  logic        good;
  logic        tch;
  logic        hch;

  always_comb begin
    // 8-bit sum wraps modulo 256
    sum  = hum_int_i + hum_frac_i + temp_int_i + temp_frac_sign_i;
    good = bus_ok_i && (sum == check_byte_i);
    hum  = 15'(hum_int_i) * 15'd100 + 15'(hum_frac_i) * 15'd10;
    mag  = 15'(temp_int_i) * 15'd100 + 15'(temp_frac_sign_i[6:0]) * 15'd10;
    // negating zero magnitude yields zero, so negative zero needs no case
    temp = temp_frac_sign_i[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    tch  = !reading_valid_i || (temp != stored_temp_i);
    hch  = !reading_valid_i || (hum != stored_hum_i);

    dec_o.ev_mask = '0;
    if (good) begin
      dec_o.ev_mask[KindRecovered] = failure_latched_i;
      dec_o.ev_mask[KindTemp]      = tch;
      dec_o.ev_mask[KindHum]       = hch;
      dec_o.ev_mask[KindChanged]   = tch || hch;
    end else begin
      dec_o.ev_mask[KindFailed]    = !failure_latched_i;
    end
    dec_o.temp = temp;
    dec_o.hum  = hum;
    dec_o.good = good;
  end

endmodule

/* design/htfd_emit.sv */
// Event emitter: holds the pending events of one frame and sends them in order.
module htfd_emit import htfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  htfd_dec_t          dec_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_kind_o,
  output logic signed [15:0] event_value_o,
  output logic               sensor_available_o,
  output logic               last_event_o
);

  logic [EvCount-1:0] mask_q, mask_d;
  logic [EvCount-1:0] pick;
  logic [EvCount-1:0] rest;
  logic signed [15:0] temp_q;
  logic [14:0]        hum_q;
  logic               avail_q;
  logic               fire;

  always_comb begin
    pick         = '0;
    event_kind_o = KindRecovered;
    priority if (mask_q[KindRecovered]) begin
      pick[KindRecovered] = 1'b1;
      event_kind_o        = KindRecovered;
    end else if (mask_q[KindTemp]) begin
      pick[KindTemp] = 1'b1;
      event_kind_o   = KindTemp;
    end else if (mask_q[KindHum]) begin
      pick[KindHum] = 1'b1;
      event_kind_o  = KindHum;
    end else if (mask_q[KindChanged]) begin
      pick[KindChanged] = 1'b1;
      event_kind_o      = KindChanged;
    end else if (mask_q[KindFailed]) begin
      pick[KindFailed] = 1'b1;
      event_kind_o     = KindFailed;
    end else begin
      // nothing pending
      pick = '0;
    end
  end

  always_comb begin
    unique case (event_kind_o)
      KindHum:    event_value_o = $signed({1'b0, hum_q});
      KindFailed: event_value_o = '0;
      default:    event_value_o = temp_q;
    endcase
  end

  assign rest               = mask_q & ~pick;
  assign out_valid_o        = |mask_q;
  assign fire               = out_valid_o && out_ready_i;
  assign last_event_o       = (rest == '0);
  assign sensor_available_o = avail_q;
  assign can_load_o         = !out_valid_o || (fire && last_event_o);

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = dec_i.ev_mask;
    end else if (fire) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      temp_q  <= dec_i.temp;
      hum_q   <= dec_i.hum;
      avail_q <= dec_i.good;
    end
  end

endmodule

/* design/humidity_temp_frame_decode_events.sv */
// Top level of the humidity/temperature sensor frame decoder with change events.
// A frame transaction is captured in an input register; while held there it
// is checked (modulo-256 sum of bytes 0..3 against byte 4, plus bus_ok),
// decoded to hundredths and compared with the stored reading, and its events
// move into the emitter while the stored state is updated. The emitter sends
// one event transaction per cycle while out_ready_i is high, in the order
// recovered, temperature changed, humidity changed, changed, or a single
// read failed; last_event_o marks the final event of a frame. A frame has
// zero to four events, and one with no events never enters the emitter; the
// first event appears once the frame has passed the input register and the
// emitter's event mask register. The next frame is decoded while the last
// event of the previous one is taken, so a steady stream runs at one event
// per cycle while out_ready_i is high. Reset clears the stored reading, so
// the first good frame always reports both values as changed.
module humidity_temp_frame_decode_events import htfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               bus_ok_i,
  input  logic [7:0]         hum_int_i,
  input  logic [7:0]         hum_frac_i,
  input  logic [7:0]         temp_int_i,
  input  logic [7:0]         temp_frac_sign_i,
  input  logic [7:0]         check_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_kind_o,
  output logic signed [15:0] event_value_o,
  output logic               sensor_available_o,
  output logic               last_event_o
);

  // Input register.
  logic       fv_q;
  logic       bus_ok_q;
  logic [7:0] hum_int_q, hum_frac_q, temp_int_q, temp_frac_sign_q, check_byte_q;

  // Stored reading and status.
  logic signed [15:0] stored_temp_q;
  logic [14:0]        stored_hum_q;
  logic               reading_valid_q;
  logic               failure_latched_q;

  htfd_dec_t dec;
  logic      can_load;
  logic      advance;
  logic      load;
  logic      in_fire;

  htfd_decode u_decode (
    .bus_ok_i          (bus_ok_q),
    .hum_int_i         (hum_int_q),
    .hum_frac_i        (hum_frac_q),
    .temp_int_i        (temp_int_q),
    .temp_frac_sign_i  (temp_frac_sign_q),
    .check_byte_i      (check_byte_q),
    .stored_temp_i     (stored_temp_q),
    .stored_hum_i      (stored_hum_q),
    .reading_valid_i   (reading_valid_q),
    .failure_latched_i (failure_latched_q),
    .dec_o             (dec)
  );

  // Advance the held frame when its events fit into the emitter, or when it
  // has none (it still updates the stored state).
  assign advance    = fv_q && ((dec.ev_mask == '0) || can_load);
  assign load       = advance && (dec.ev_mask != '0);
  assign in_ready_o = !fv_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (in_ready_o) begin
      fv_q <= in_valid_i;
    end
  end

  // Hold the frame payload until it advances.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bus_ok_q         <= bus_ok_i;
      hum_int_q        <= hum_int_i;
      hum_frac_q       <= hum_frac_i;
      temp_int_q       <= temp_int_i;
      temp_frac_sign_q <= temp_frac_sign_i;
      check_byte_q     <= check_byte_i;
    end
  end

  // Update the stored reading as a frame leaves the input register; a bad
  // frame keeps the values and only sets the failure latch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_temp_q     <= '0;
      stored_hum_q      <= '0;
      reading_valid_q   <= 1'b0;
      failure_latched_q <= 1'b0;
    end else if (advance) begin
      if (dec.good) begin
        stored_temp_q     <= dec.temp;
        stored_hum_q      <= dec.hum;
        reading_valid_q   <= 1'b1;
        failure_latched_q <= 1'b0;
      end else begin
        failure_latched_q <= 1'b1;
      end
    end
  end

  htfd_emit u_emit (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (load),
    .dec_i              (dec),
    .can_load_o         (can_load),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .event_kind_o       (event_kind_o),
    .event_value_o      (event_value_o),
    .sensor_available_o (sensor_available_o),
    .last_event_o       (last_event_o)
  );

endmodule
